[rtl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psc assertion failed");

// next-cycle implication, disabled during reset
`define PSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psc assertion failed");

`endif

[rtl/psc_pkg.sv]
// package for the sequence lock checker: types, codes and helpers
package psc_pkg;

   localparam int WordBits  = 16;
   localparam int LoadBits  = 15;
   localparam int CountBits = 32;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   typedef enum logic [1:0] {
      MODE_MATCH0 = 2'd0,
      MODE_MATCH1 = 2'd1,
      MODE_MATCH2 = 2'd2,
      MODE_LOCKED = 2'd3
   } mode_type;

   typedef logic [WordBits-1:0]  word_type;
   typedef logic [CountBits-1:0] count_type;

   function automatic count_type sat_add(input count_type c, input logic [1:0] d);
      logic [CountBits:0] sum;
      sum = {1'b0, c} + (CountBits+1)'(d);
      return sum[CountBits] ? '1 : sum[CountBits-1:0];
   endfunction

endpackage

[rtl/psc_req_if.sv]
// input channel: check or load transfers
interface psc_req_if;
   import psc_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   word_type            data_word;
   logic [LoadBits-1:0] load_address;

   modport source (output valid, op, data_word, load_address, input ready);
   modport sink   (input valid, op, data_word, load_address, output ready);
endinterface

[rtl/psc_rsp_if.sv]
// result channel: one transfer per checked word
interface psc_rsp_if;
   import psc_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  checker_mode;
   logic        word_ok;
   logic        word_error;
   logic        lock_lost;
   word_type    expected_word;
   count_type   total_words;
   count_type   right_words;
   count_type   run_length;

   modport source (output valid, checker_mode, word_ok, word_error, lock_lost,
                   expected_word, total_words, right_words, run_length,
                   input ready);
   modport sink   (input valid, checker_mode, word_ok, word_error, lock_lost,
                   expected_word, total_words, right_words, run_length,
                   output ready);
endinterface

[rtl/psc_ram.sv]
// generic simple dual-port ram with registered read
module psc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/prbs_sequence_lock_checker_unit.sv]
// top level of the sequence lock checker
//
// Compares received words against a reference sequence held in an on-chip
// table of SEQ_DEPTH 16-bit words. Load transfers (op = 1) write one table
// entry and give no result; loads to addresses at or beyond SEQ_DEPTH are
// dropped. Check transfers (op = 0) give one result each. The block takes one
// transfer per cycle, back to back, while the result channel is not stalled;
// a check's result goes through the table's registered read, then the result
// register. The table address of each check follows from the mode and index
// that the previous check leaves, so that update is forwarded to the read port
// in the same cycle. Table entries must be loaded before a check reads them.
// Mode, counters and index change only when a result enters the result
// register, so the counter fields show the state as of that result.
module prbs_sequence_lock_checker_unit
   import psc_pkg::*;
#(
   parameter int SEQ_DEPTH = 32768
) (
   input logic      clock,
   input logic      reset,
   psc_req_if.sink  req_if,
   psc_rsp_if.source rsp_if
);

   localparam int AddrBits = $clog2(SEQ_DEPTH);

   typedef logic [AddrBits-1:0] addr_type;

   logic      accept;
   logic      chk_accept;
   logic      load_en;
   logic      out_ready;
   logic      s1_adv;
   logic      hit;
   logic [2:0] hist_shift;
   word_type  rd_data;
   addr_type  rd_addr;
   addr_type  index_next;

   logic      s1_valid_ff, s1_valid_in;
   word_type  s1_word_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      ok_ff, ok_in;
   logic      err_ff, err_in;
   logic      lost_ff, lost_in;
   word_type  expected_ff, expected_in;

   mode_type  mode_ff, mode_in;
   logic [2:0] hist_ff, hist_in;
   addr_type  index_ff, index_in;
   count_type total_ff, total_in;
   count_type right_ff, right_in;
   count_type run_ff, run_in;

   // handshake
   assign out_ready    = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv       = s1_valid_ff && out_ready;
   assign req_if.ready = !s1_valid_ff || out_ready;
   assign accept       = req_if.valid && req_if.ready;
   assign chk_accept   = accept && (req_if.op == OP_CHECK);
   assign load_en      = accept && (req_if.op == OP_LOAD)
                         && (32'(req_if.load_address) < SEQ_DEPTH);

   assign hit        = (s1_word_ff == rd_data);
   assign hist_shift = {hist_ff[1:0], hit};
   assign index_next = (index_ff == AddrBits'(SEQ_DEPTH - 1)) ? '0 : index_ff + 1'b1;

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (s1_adv) begin
         unique case (mode_ff)
            MODE_MATCH0: mode_in = hit ? MODE_MATCH1 : MODE_MATCH0;
            MODE_MATCH1: mode_in = hit ? MODE_MATCH2 : MODE_MATCH0;
            MODE_MATCH2: mode_in = hit ? MODE_LOCKED : MODE_MATCH0;
            MODE_LOCKED: mode_in = (hist_shift == 3'b000) ? MODE_MATCH0 : MODE_LOCKED;
            default:     mode_in = MODE_MATCH0;
         endcase
      end
   end

   // counters, history, index and result fields
   always_comb begin
      hist_in     = hist_ff;
      index_in    = index_ff;
      total_in    = total_ff;
      right_in    = right_ff;
      run_in      = run_ff;
      ok_in       = 1'b0;
      err_in      = 1'b0;
      lost_in     = 1'b0;
      expected_in = '0;
      if (s1_adv) begin
         total_in = sat_add(total_ff, 2'd1);
         unique case (mode_ff) inside
            MODE_MATCH0, MODE_MATCH1: begin
            end
            MODE_MATCH2: begin
               if (hit) begin
                  hist_in  = 3'b111;
                  right_in = sat_add(right_ff, 2'd3);
                  run_in   = sat_add(run_ff, 2'd3);
                  index_in = AddrBits'(3);
               end
            end
            MODE_LOCKED: begin
               expected_in = rd_data;
               hist_in     = hist_shift;
               index_in    = index_next;
               if (hit) begin
                  ok_in    = 1'b1;
                  right_in = sat_add(right_ff, 2'd1);
                  run_in   = sat_add(run_ff, 2'd1);
               end else begin
                  err_in = 1'b1;
                  run_in = '0;
                  if (hist_shift == 3'b000) begin
                     lost_in  = 1'b1;
                     index_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // read address forwarded from the state the previous check leaves
   always_comb begin
      unique case (mode_in)
         MODE_MATCH0: rd_addr = AddrBits'(0);
         MODE_MATCH1: rd_addr = AddrBits'(1);
         MODE_MATCH2: rd_addr = AddrBits'(2);
         MODE_LOCKED: rd_addr = index_in;
         default:     rd_addr = AddrBits'(0);
      endcase
   end

   assign s1_valid_in  = chk_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   psc_ram #(
      .WIDTH (WordBits),
      .DEPTH (SEQ_DEPTH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AddrBits'(req_if.load_address)),
      .wr_data (req_if.data_word),
      .rd_en   (chk_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_MATCH0;
         hist_ff      <= 3'b000;
         index_ff     <= '0;
         total_ff     <= '0;
         right_ff     <= '0;
         run_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         hist_ff      <= hist_in;
         index_ff     <= index_in;
         total_ff     <= total_in;
         right_ff     <= right_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chk_accept) begin
         s1_word_ff <= req_if.data_word;
      end
      if (s1_adv) begin
         ok_ff       <= ok_in;
         err_ff      <= err_in;
         lost_ff     <= lost_in;
         expected_ff <= expected_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.checker_mode  = mode_ff;
   assign rsp_if.word_ok       = ok_ff;
   assign rsp_if.word_error    = err_ff;
   assign rsp_if.lock_lost     = lost_ff;
   assign rsp_if.expected_word = expected_ff;
   assign rsp_if.total_words   = total_ff;
   assign rsp_if.right_words   = right_ff;
   assign rsp_if.run_length    = run_ff;

endmodule

[rtl/psc_checker.sv]
// port-level assertions for the sequence lock checker and their bind
`include "assert_macros.svh"

module psc_checker
   import psc_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic [1:0] rsp_mode,
   input logic      rsp_ok,
   input logic      rsp_err,
   input logic      rsp_lost,
   input count_type rsp_total
);

   logic searching;
   logic stalled;

   assign searching = (rsp_mode == MODE_MATCH0);
   assign stalled   = rsp_valid && !rsp_ready;

   `PSC_ASSERT_IMP(a_ok_err_excl, clock, reset, rsp_valid, !(rsp_ok && rsp_err))
   `PSC_ASSERT_IMP(a_ok_locked, clock, reset, rsp_valid && rsp_ok, rsp_mode == MODE_LOCKED)
   `PSC_ASSERT_IMP(a_lost_search, clock, reset, rsp_valid && rsp_lost, rsp_err && searching)
   `PSC_ASSERT_NXT(a_stall_hold, clock, reset, stalled, rsp_valid && $stable(rsp_total))

endmodule

bind prbs_sequence_lock_checker_unit psc_checker u_psc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_mode  (rsp_if.checker_mode),
   .rsp_ok    (rsp_if.word_ok),
   .rsp_err   (rsp_if.word_error),
   .rsp_lost  (rsp_if.lock_lost),
   .rsp_total (rsp_if.total_words)
);
